// ===== design/rmd_pkg.sv =====
// Package for the RIPEMD-160 hash engine: round constants, word order and rotate tables.
// Used by rmd_round and ripemd160_hash_engine; depends on nothing.
package rmd_pkg;

   localparam int WordWidth  = 32;
   localparam int RoundCount = 80;

   typedef logic [31:0] word_type;

   // Initial chaining value.
   function automatic word_type init_word(input logic [2:0] idx);
      word_type r;
      r = 32'h0;
      case (idx)
         3'd0: r = 32'h67452301;
         3'd1: r = 32'hEFCDAB89;
         3'd2: r = 32'h98BADCFE;
         3'd3: r = 32'h10325476;
         3'd4: r = 32'hC3D2E1F0;
         default: r = 32'h0;
      endcase
      return r;
   endfunction

   function automatic word_type left_k(input logic [2:0] g);
      word_type r;
      r = 32'h0;
      case (g)
         3'd1: r = 32'h5A827999;
         3'd2: r = 32'h6ED9EBA1;
         3'd3: r = 32'h8F1BBCDC;
         3'd4: r = 32'hA953FD4E;
         default: r = 32'h0;
      endcase
      return r;
   endfunction

   function automatic word_type right_k(input logic [2:0] g);
      word_type r;
      r = 32'h0;
      case (g)
         3'd0: r = 32'h50A28BE6;
         3'd1: r = 32'h5C4DD124;
         3'd2: r = 32'h6D703EF3;
         3'd3: r = 32'h7A6D76E9;
         default: r = 32'h0;
      endcase
      return r;
   endfunction

   localparam logic [3:0] LEFT_W [RoundCount] = '{
      0,1,2,3,4,5,6,7,8,9,10,11,12,13,14,15,
      7,4,13,1,10,6,15,3,12,0,9,5,2,14,11,8,
      3,10,14,4,9,15,8,1,2,7,0,6,13,11,5,12,
      1,9,11,10,0,8,12,4,13,3,7,15,14,5,6,2,
      4,0,5,9,7,12,2,10,14,1,3,8,11,6,15,13};
   localparam logic [3:0] RIGHT_W [RoundCount] = '{
      5,14,7,0,9,2,11,4,13,6,15,8,1,10,3,12,
      6,11,3,7,0,13,5,10,14,15,8,12,4,9,1,2,
      15,5,1,3,7,14,6,9,11,8,12,2,10,0,4,13,
      8,6,4,1,3,11,15,0,5,12,2,13,9,7,10,14,
      12,15,10,4,1,5,8,7,6,2,13,14,0,3,9,11};
   localparam logic [4:0] LEFT_S [RoundCount] = '{
      11,14,15,12,5,8,7,9,11,13,14,15,6,7,9,8,
      7,6,8,13,11,9,7,15,7,12,15,9,11,7,13,12,
      11,13,6,7,14,9,13,15,14,8,13,6,5,12,7,5,
      11,12,14,15,14,15,9,8,9,14,5,6,8,6,5,12,
      9,15,5,11,6,8,13,12,5,12,13,14,11,8,5,6};
   localparam logic [4:0] RIGHT_S [RoundCount] = '{
      8,9,9,11,13,15,15,5,7,7,8,11,14,14,12,6,
      9,13,15,7,12,8,9,11,7,7,12,7,6,15,13,11,
      9,7,15,11,8,6,6,14,12,13,5,14,13,13,7,5,
      15,5,8,11,14,14,6,14,6,9,12,9,12,5,15,8,
      8,5,12,9,12,5,14,6,8,13,6,5,15,13,11,11};

   function automatic word_type rotl(input word_type x, input logic [4:0] n);
      logic [63:0] d;
      d = {x, x} << n;
      return d[63:32];
   endfunction

   function automatic word_type bool_fn(input logic [2:0] sel, input word_type x,
                                        input word_type y, input word_type z);
      word_type r;
      r = x ^ y ^ z;
      case (sel)
         3'd0: r = x ^ y ^ z;
         3'd1: r = (x & y) | (~x & z);
         3'd2: r = (x | ~y) ^ z;
         3'd3: r = (x & z) | (y & ~z);
         default: r = x ^ (y | ~z);
      endcase
      return r;
   endfunction

endpackage

// ===== design/rmd_ram.sv =====
// Generic RAM with one write port and one registered read port.
// No dependencies.
module rmd_ram #(
   parameter int Width = 32,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// ===== design/rmd_round.sv =====
// One RIPEMD-160 round step for one line, shared over all 80 rounds.
// Depends on rmd_pkg.
module rmd_round (
   input  rmd_pkg::word_type v_in [5],
   input  rmd_pkg::word_type x,
   input  rmd_pkg::word_type k,
   input  logic [2:0]        fsel,
   input  logic [4:0]        s,
   output rmd_pkg::word_type v_out [5]
);
   rmd_pkg::word_type sum;

   // Add, rotate, add, then shift the five words along.
   always_comb begin
      sum = v_in[0] + rmd_pkg::bool_fn(fsel, v_in[1], v_in[2], v_in[3]) + x + k;
      v_out[1] = rmd_pkg::rotl(sum, s) + v_in[4];
      v_out[0] = v_in[4];
      v_out[4] = v_in[3];
      v_out[3] = rmd_pkg::rotl(v_in[2], 5'd10);
      v_out[2] = v_in[1];
   end
endmodule

// ===== design/ripemd160_hash_engine.sv =====
// Top level of the RIPEMD-160 hash engine: byte packing, padding, round sequencer.
// Depends on rmd_pkg, rmd_ram and rmd_round.
//
// Channel | Direction | Contents
// req     | in        | tdata = data_byte, tuser = byte_valid, tlast = last_byte
// rsp     | out       | tdata = digest_word, tuser = word_index, tlast = last_word
//
// A byte that does not finish a block leaves the engine idle and ready. A byte
// that finishes a block starts a compression: a load state, the 80 rounds, in
// which the two lines take turns because they share the block memory's single
// read port and the round unit, and a final update state.
// A last request adds padding at one byte per cycle, one or two compressions,
// and five result words, each offered until taken. Reset is synchronous and returns the initial value.
// The engine holds req_tready low while it works and while results wait.
module ripemd160_hash_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] byte_valid
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] digest_word
   output logic [2:0]  rsp_tuser,   // [2:0] word_index
   output logic        rsp_tlast
);
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_PAD  = 3'd1;
   localparam logic [2:0] ST_LOAD = 3'd2;
   localparam logic [2:0] ST_RND  = 3'd3;
   localparam logic [2:0] ST_FIN  = 3'd4;
   localparam logic [2:0] ST_OUT  = 3'd5;

   logic [2:0]  state_ff, state_in;
   logic [60:0] count_ff, count_in;
   logic [5:0]  pos_ff, pos_in;          // byte position inside the block
   logic        pad_ff, pad_in;          // the 0x80 marker byte has been placed
   logic        fin_ff, fin_in;          // the message has ended, padding under way
   logic        len_ff, len_in;          // the length goes into the current block
   logic [63:0] bits_ff, bits_in;
   logic [6:0]  round_ff, round_in;
   logic        half_ff, half_in;        // 0: left line step, 1: right line step
   logic [2:0]  oidx_ff, oidx_in;
   rmd_pkg::word_type cv_ff [5];
   rmd_pkg::word_type cv_in [5];
   rmd_pkg::word_type lw_ff [5];
   rmd_pkg::word_type lw_in [5];
   rmd_pkg::word_type rw_ff [5];
   rmd_pkg::word_type rw_in [5];
   rmd_pkg::word_type part_ff, part_in;  // word under assembly
   rmd_pkg::word_type line_in [5];
   rmd_pkg::word_type line_out [5];

   logic        wr_en;
   logic [3:0]  rd_addr;
   rmd_pkg::word_type rd_data, rnd_k;
   logic [7:0]  put_byte;
   logic        put_en;
   logic [2:0]  grp, fsel;
   logic [4:0]  rnd_s;
   logic [6:0]  rnd_idx;

   // Block memory of 16 little-endian words.
   rmd_ram #(.Width(rmd_pkg::WordWidth), .Depth(16)) u_block (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(pos_ff[5:2]),
      .wr_data({put_byte, part_ff[31:8]}),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // Shared round unit, alternating between the two lines.
   rmd_round u_round (
      .v_in (line_in),
      .x    (rd_data),
      .k    (rnd_k),
      .fsel (fsel),
      .s    (rnd_s),
      .v_out(line_out)
   );

   // Round schedule: each word is fetched through the registered read port ahead of the step that uses it.
   always_comb begin
      rnd_idx = round_ff;
      grp     = 3'(round_ff >> 4);
      if (state_ff == ST_RND && half_ff) begin
         rd_addr = rmd_pkg::LEFT_W[(round_ff == 7'd79) ? 7'd79 : round_ff + 7'd1];
      end else begin
         rd_addr = rmd_pkg::RIGHT_W[rnd_idx];
      end
      if (state_ff == ST_LOAD) begin
         rd_addr = rmd_pkg::LEFT_W[0];
      end
      if (half_ff) begin
         fsel    = 3'd4 - grp;
         rnd_k   = rmd_pkg::right_k(grp);
         rnd_s   = rmd_pkg::RIGHT_S[rnd_idx];
         line_in = rw_ff;
      end else begin
         fsel    = grp;
         rnd_k   = rmd_pkg::left_k(grp);
         rnd_s   = rmd_pkg::LEFT_S[rnd_idx];
         line_in = lw_ff;
      end
   end

   // Byte being placed: message byte, or padding and length bytes.
   always_comb begin
      put_en   = 1'b0;
      put_byte = req_tdata;
      if (state_ff == ST_IDLE) begin
         put_en = req_tvalid && req_tuser;
      end else if (state_ff == ST_PAD) begin
         put_en = 1'b1;
         if (!pad_ff) begin
            put_byte = 8'h80;
         end else if (len_ff && pos_ff >= 6'd56) begin
            put_byte = bits_ff[8*(pos_ff[2:0]) +: 8];
         end else begin
            put_byte = 8'h00;
         end
      end
      wr_en = put_en && (pos_ff[1:0] == 2'd3);
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      pos_in   = pos_ff;
      pad_in   = pad_ff;
      fin_in   = fin_ff;
      len_in   = len_ff;
      bits_in  = bits_ff;
      round_in = round_ff;
      half_in  = half_ff;
      oidx_in  = oidx_ff;
      cv_in    = cv_ff;
      lw_in    = lw_ff;
      rw_in    = rw_ff;
      part_in  = part_ff;
      if (put_en) begin
         part_in = {put_byte, part_ff[31:8]};
         pos_in  = pos_ff + 6'd1;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser) begin
                  count_in = count_ff + 61'd1;
               end
               // The end mark latches the bit length and starts the padding.
               if (req_tlast) begin
                  bits_in = {count_in, 3'b000};
                  fin_in  = 1'b1;
                  pad_in  = 1'b0;
                  len_in  = 1'b0;
               end
               if (req_tuser && pos_ff == 6'd63) begin
                  state_in = ST_LOAD;
               end else if (req_tlast) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            // The length fits behind the marker only when the marker lands before byte 56.
            if (!pad_ff) begin
               pad_in = 1'b1;
               len_in = (pos_ff < 6'd56);
            end
            if (pos_ff == 6'd63) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            lw_in    = cv_ff;
            rw_in    = cv_ff;
            round_in = 7'd0;
            half_in  = 1'b0;
            state_in = ST_RND;
         end
         ST_RND: begin
            if (half_ff) begin
               rw_in    = line_out;
               round_in = round_ff + 7'd1;
               if (round_ff == 7'd79) begin
                  state_in = ST_FIN;
               end
            end else begin
               lw_in = line_out;
            end
            half_in = !half_ff;
         end
         ST_FIN: begin
            cv_in[0] = cv_ff[1] + lw_ff[2] + rw_ff[3];
            cv_in[1] = cv_ff[2] + lw_ff[3] + rw_ff[4];
            cv_in[2] = cv_ff[3] + lw_ff[4] + rw_ff[0];
            cv_in[3] = cv_ff[4] + lw_ff[0] + rw_ff[1];
            cv_in[4] = cv_ff[0] + lw_ff[1] + rw_ff[2];
            // A plain block goes idle; the length block ends the message; others pad on.
            if (!fin_ff) begin
               state_in = ST_IDLE;
            end else if (len_ff) begin
               state_in = ST_OUT;
               oidx_in  = 3'd0;
            end else begin
               state_in = ST_PAD;
               len_in   = pad_ff;
            end
         end
         ST_OUT: begin
            if (rsp_tready) begin
               oidx_in = oidx_ff + 3'd1;
               if (oidx_ff == 3'd4) begin
                  state_in = ST_IDLE;
                  oidx_in  = 3'd0;
                  fin_in   = 1'b0;
                  pad_in   = 1'b0;
                  len_in   = 1'b0;
                  for (int i = 0; i < 5; i++) begin
                     cv_in[i] = rmd_pkg::init_word(3'(i));
                  end
                  count_in = '0;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         pos_ff    <= '0;
         pad_ff    <= 1'b0;
         fin_ff    <= 1'b0;
         len_ff    <= 1'b0;
         round_ff  <= '0;
         half_ff   <= 1'b0;
         oidx_ff   <= '0;
         for (int i = 0; i < 5; i++) begin
            cv_ff[i] <= rmd_pkg::init_word(3'(i));
         end
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         pos_ff    <= pos_in;
         pad_ff    <= pad_in;
         fin_ff    <= fin_in;
         len_ff    <= len_in;
         round_ff  <= round_in;
         half_ff   <= half_in;
         oidx_ff   <= oidx_in;
         cv_ff     <= cv_in;
      end
      bits_ff <= bits_in;
      lw_ff   <= lw_in;
      rw_ff   <= rw_in;
      part_ff <= part_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata  = cv_ff[oidx_ff];
   assign rsp_tuser  = oidx_ff;
   assign rsp_tlast  = (oidx_ff == 3'd4);

`ifndef SYNTHESIS
   // No request is taken while results are offered.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(rsp_tvalid && req_tready)) else $error("request taken during output");
   // The word index stays within the digest.
   a_idx: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser <= 3'd4)) else $error("bad word index");
   // After the final word is taken the engine returns to idle.
   a_ret: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> req_tready)
      else $error("no return to idle");
`endif
endmodule
